// ===== hw/rtl/catm_pkg.sv =====
// Shared types, constants and helpers of the calendar alarm table matcher.
// Used by the channel interfaces, the controller, the datapath and the checker.
package catm_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int KEY_WIDTH  = 16;
  localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

  localparam int OP_W       = 2;
  localparam int JOB_KEY_W  = 16;
  localparam int MIN_W      = 7;
  localparam int HOUR_W     = 6;
  localparam int DAY_W      = 6;
  localparam int MON_W      = 5;
  localparam int WDAY_W     = 4;
  localparam int YEAR_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = YEAR_W'(120);
  // No minute seen yet reads as minus one
  localparam logic [MIN_W-1:0]  NO_MINUTE      = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_IGNORE_SEEN,
    CMD_IGNORE_YEAR,
    CMD_TICK_SCAN,
    CMD_UNUSED_OP,
    CMD_SKIP,
    CMD_SET_PEND,
    CMD_EMIT_PEND,
    CMD_UPDATE,
    CMD_REMOVE,
    CMD_TICK_END,
    CMD_ADD_END,
    CMD_REMOVE_END
  } cmd_e;

  typedef struct packed {
    logic signed [MIN_W-1:0]  minute;
    logic signed [HOUR_W-1:0] hour;
    logic signed [DAY_W-1:0]  day;
    logic signed [MON_W-1:0]  month;
    logic signed [WDAY_W-1:0] weekday;
  } pattern_t;

  typedef struct packed {
    op_e                  op;
    logic [KEY_WIDTH-1:0] key;
    pattern_t             now;
    logic [YEAR_W-1:0]    year;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic                  fired;
    logic [JOB_KEY_W-1:0]  fired_key;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    cmd_e cmd;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic minute_seen;
    logic year_low;
    logic scan_end;
    logic hit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

  // A negative pattern field is a wildcard
  function automatic logic pattern_match(pattern_t p, pattern_t now);
    logic miss;
    miss = (!p.minute[MIN_W-1]   && (p.minute  != now.minute))  ||
           (!p.hour[HOUR_W-1]    && (p.hour    != now.hour))    ||
           (!p.day[DAY_W-1]      && (p.day     != now.day))     ||
           (!p.month[MON_W-1]    && (p.month   != now.month))   ||
           (!p.weekday[WDAY_W-1] && (p.weekday != now.weekday));
    return !miss;
  endfunction

  function automatic out_item_t mk_out(status_e status, logic fired,
                                       logic [KEY_WIDTH-1:0] key,
                                       logic [SLOT_W-1:0] slot, logic last);
    out_item_t o;
    o.status     = status;
    o.fired      = fired;
    o.fired_key  = JOB_KEY_W'(key);
    o.slot_index = SLOT_IDX_W'(slot);
    o.last       = last;
    return o;
  endfunction

endpackage

// ===== hw/rtl/catm_if.sv =====
// Valid/ready channel interfaces for command beats in and result beats out.
// Depends on catm_pkg for the field widths.
interface catm_in_if import catm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [JOB_KEY_W-1:0]     job_key;
  logic signed [MIN_W-1:0]  minute_field;
  logic signed [HOUR_W-1:0] hour_field;
  logic signed [DAY_W-1:0]  day_field;
  logic signed [MON_W-1:0]  month_field;
  logic signed [WDAY_W-1:0] weekday_field;
  logic [YEAR_W-1:0]        year_field;

  modport source (output valid, op, job_key, minute_field, hour_field, day_field,
                  month_field, weekday_field, year_field, input ready);
  modport sink (input valid, op, job_key, minute_field, hour_field, day_field,
                month_field, weekday_field, year_field, output ready);
endinterface

interface catm_out_if import catm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  fired;
  logic [JOB_KEY_W-1:0]  fired_key;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  last;

  modport source (output valid, status, fired, fired_key, slot_index, last,
                  input ready);
  modport sink (input valid, status, fired, fired_key, slot_index, last,
                output ready);
endinterface

// ===== hw/rtl/catm_ctrl.sv =====
// Sequencing state machine of the alarm table matcher: one command to the
// datapath per cycle. Depends on catm_pkg.
module catm_ctrl import catm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.cmd     = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PRE;
        end
      end
      S_PRE: begin
        if (status_i.out_free) begin
          case (status_i.op)
            OP_TICK: begin
              if (status_i.minute_seen) begin
                cmd_o.cmd = CMD_IGNORE_SEEN;
                state_d   = S_IDLE;
              end else if (status_i.year_low) begin
                cmd_o.cmd = CMD_IGNORE_YEAR;
                state_d   = S_IDLE;
              end else begin
                cmd_o.cmd = CMD_TICK_SCAN;
                state_d   = S_SCAN;
              end
            end
            OP_ADD, OP_REMOVE: state_d = S_SCAN;
            default: begin
              cmd_o.cmd = CMD_UNUSED_OP;
              state_d   = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          state_d = S_FINAL;
        end else if (!status_i.hit) begin
          cmd_o.cmd = CMD_SKIP;
        end else begin
          case (status_i.op)
            OP_TICK: begin
              // hold the newest match back until we know whether it is the last
              if (!status_i.pend_valid) begin
                cmd_o.cmd = CMD_SET_PEND;
              end else if (status_i.out_free) begin
                cmd_o.cmd = CMD_EMIT_PEND;
              end
            end
            OP_ADD: begin
              if (status_i.out_free) begin
                cmd_o.cmd = CMD_UPDATE;
                state_d   = S_IDLE;
              end
            end
            OP_REMOVE: begin
              if (status_i.out_free) begin
                cmd_o.cmd = CMD_REMOVE;
                state_d   = S_IDLE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FINAL: begin
        if (status_i.out_free) begin
          case (status_i.op)
            OP_TICK: cmd_o.cmd = CMD_TICK_END;
            OP_ADD:  cmd_o.cmd = CMD_ADD_END;
            default: cmd_o.cmd = CMD_REMOVE_END;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ===== hw/rtl/catm_dp.sv =====
// Datapath of the alarm table matcher: slot table, scan counter, pending
// match, minute and year registers, result register. Depends on catm_pkg.
module catm_dp import catm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [YEAR_W-1:0] cfg_wdata_i,
  input  in_item_t          in_item_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  // Slot table
  logic [MAX_SLOTS-1:0] active_q, active_d;
  logic [KEY_WIDTH-1:0] key_mem [MAX_SLOTS];
  pattern_t             pat_mem [MAX_SLOTS];

  logic                 wr_pat;
  logic                 wr_key;
  logic [SLOT_W-1:0]    wr_addr;

  // Control registers
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 free_found_q, free_found_d;
  logic [MIN_W-1:0]     last_min_q, last_min_d;
  logic [YEAR_W-1:0]    min_year_q, min_year_d;
  logic                 out_valid_q, out_valid_d;

  // Payload registers
  in_item_t             item_q, item_d;
  logic [KEY_WIDTH-1:0] pend_key_q, pend_key_d;
  logic [SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic [SLOT_W-1:0]    free_slot_q, free_slot_d;
  out_item_t            out_q, out_d;

  logic [SLOT_W-1:0]    idx;
  logic                 hit;
  logic                 room;

  assign idx  = cnt_q[SLOT_W-1:0];
  assign room = (used_q != CNT_W'(MAX_SLOTS));
  assign hit  = active_q[idx] &&
                ((item_q.op == OP_TICK) ? pattern_match(pat_mem[idx], item_q.now)
                                        : (key_mem[idx] == item_q.key));

  always_comb begin
    status_o.op          = item_q.op;
    status_o.minute_seen = (item_q.now.minute == last_min_q);
    status_o.year_low    = (item_q.year < min_year_q);
    status_o.scan_end    = (cnt_q == used_q);
    status_o.hit         = hit;
    status_o.pend_valid  = pend_valid_q;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    active_d     = active_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    pend_valid_d = pend_valid_q;
    free_found_d = free_found_q;
    last_min_d   = last_min_q;
    min_year_d   = min_year_q;
    out_valid_d  = out_valid_q;
    item_d       = item_q;
    pend_key_d   = pend_key_q;
    pend_slot_d  = pend_slot_q;
    free_slot_d  = free_slot_q;
    out_d        = out_q;
    wr_pat       = 1'b0;
    wr_key       = 1'b0;
    wr_addr      = idx;

    if (cfg_we_i) begin
      min_year_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.capture) begin
      item_d       = in_item_i;
      cnt_d        = '0;
      pend_valid_d = 1'b0;
      free_found_d = 1'b0;
    end

    case (cmd_i.cmd)
      CMD_IGNORE_SEEN: begin
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_IGNORED, 1'b0, '0, '0, 1'b1);
      end
      CMD_IGNORE_YEAR: begin
        last_min_d  = item_q.now.minute;
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_IGNORED, 1'b0, '0, '0, 1'b1);
      end
      CMD_TICK_SCAN: begin
        last_min_d = item_q.now.minute;
      end
      CMD_UNUSED_OP: begin
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_IGNORED, 1'b0, item_q.key, '0, 1'b1);
      end
      CMD_SKIP: begin
        cnt_d = cnt_q + CNT_W'(1);
        // remember the first hole for an add that finds no matching key
        if (item_q.op == OP_ADD && !active_q[idx] && !free_found_q) begin
          free_found_d = 1'b1;
          free_slot_d  = idx;
        end
      end
      CMD_SET_PEND: begin
        cnt_d        = cnt_q + CNT_W'(1);
        pend_valid_d = 1'b1;
        pend_key_d   = key_mem[idx];
        pend_slot_d  = idx;
      end
      CMD_EMIT_PEND: begin
        cnt_d       = cnt_q + CNT_W'(1);
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_OK, 1'b1, pend_key_q, pend_slot_q, 1'b0);
        pend_key_d  = key_mem[idx];
        pend_slot_d = idx;
      end
      CMD_UPDATE: begin
        wr_pat      = 1'b1;
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_OK, 1'b0, item_q.key, idx, 1'b1);
      end
      CMD_REMOVE: begin
        active_d[idx] = 1'b0;
        out_valid_d   = 1'b1;
        out_d         = mk_out(ST_OK, 1'b0, item_q.key, idx, 1'b1);
      end
      CMD_TICK_END: begin
        out_valid_d = 1'b1;
        if (pend_valid_q) begin
          out_d = mk_out(ST_OK, 1'b1, pend_key_q, pend_slot_q, 1'b1);
        end else begin
          out_d = mk_out(ST_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      CMD_ADD_END: begin
        out_valid_d = 1'b1;
        if (free_found_q) begin
          wr_pat                = 1'b1;
          wr_key                = 1'b1;
          wr_addr               = free_slot_q;
          active_d[free_slot_q] = 1'b1;
          out_d = mk_out(ST_OK, 1'b0, item_q.key, free_slot_q, 1'b1);
        end else if (room) begin
          wr_pat                          = 1'b1;
          wr_key                          = 1'b1;
          wr_addr                         = used_q[SLOT_W-1:0];
          active_d[used_q[SLOT_W-1:0]]    = 1'b1;
          used_d                          = used_q + CNT_W'(1);
          out_d = mk_out(ST_OK, 1'b0, item_q.key, used_q[SLOT_W-1:0], 1'b1);
        end else begin
          out_d = mk_out(ST_FULL, 1'b0, item_q.key, '0, 1'b1);
        end
      end
      CMD_REMOVE_END: begin
        out_valid_d = 1'b1;
        out_d       = mk_out(ST_NOT_FOUND, 1'b0, item_q.key, '0, 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      cnt_q        <= '0;
      used_q       <= '0;
      pend_valid_q <= 1'b0;
      free_found_q <= 1'b0;
      last_min_q   <= NO_MINUTE;
      min_year_q   <= MIN_YEAR_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      cnt_q        <= cnt_d;
      used_q       <= used_d;
      pend_valid_q <= pend_valid_d;
      free_found_q <= free_found_d;
      last_min_q   <= last_min_d;
      min_year_q   <= min_year_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pend_key_q  <= pend_key_d;
    pend_slot_q <= pend_slot_d;
    free_slot_q <= free_slot_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_pat) begin
      pat_mem[wr_addr] <= item_q.now;
    end
    if (wr_key) begin
      key_mem[wr_addr] <= item_q.key;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/calendar_alarm_table_matcher_top.sv =====
// Top level of the calendar alarm table matcher: controller plus datapath.
// Depends on catm_pkg, catm_if, catm_ctrl and catm_dp.
//
//  channel   dir  handshake           beat contents
//  in_i      in   valid/ready         op, job_key, five time fields, year
//  out_o     out  valid/ready         status, fired, fired_key, slot_index, last
//  cfg       in   cfg_we_i (no wait)  min_valid_year
//
// An item is handled in steps: take the beat, check the op and the tick
// minute, scan the table slot by slot up to used_count (the high-water mark,
// at most MAX_SLOTS), see the scan end, finish.
// A remove or an update that hits ends the scan early; an ignored tick or an
// unused op ends after the op check, with no scan.
// The scan reads one slot per cycle unless a hit waits on a stalled result.
// A result beat waits in the output register; a stalled sink holds the scan,
// and the next item is taken while the final beat of the previous one is
// still waiting. Reset leaves the table empty and needs no clearing pass.
module calendar_alarm_table_matcher_top import catm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [YEAR_W-1:0] cfg_wdata_i,
  catm_in_if.sink           in_i,
  catm_out_if.source        out_o
);

  in_item_t   in_item;
  out_item_t  out_item;
  dp_status_t dp_status;
  ctrl_cmd_t  ctrl_cmd;
  logic       in_ready;
  logic       out_valid;

  always_comb begin
    in_item.op          = op_e'(in_i.op);
    in_item.key         = KEY_WIDTH'(in_i.job_key);
    in_item.now.minute  = in_i.minute_field;
    in_item.now.hour    = in_i.hour_field;
    in_item.now.day     = in_i.day_field;
    in_item.now.month   = in_i.month_field;
    in_item.now.weekday = in_i.weekday_field;
    in_item.year        = in_i.year_field;
  end

  catm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  catm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.status     = out_item.status;
  assign out_o.fired      = out_item.fired;
  assign out_o.fired_key  = out_item.fired_key;
  assign out_o.slot_index = out_item.slot_index;
  assign out_o.last       = out_item.last;

endmodule

// ===== hw/rtl/catm_checker.sv =====
// Port-level checks of the alarm table matcher, attached to the top level by
// the bind at the end. Depends on catm_pkg.
module catm_checker import catm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [STATUS_W-1:0]   out_status_i,
  input logic                  out_fired_i,
  input logic [JOB_KEY_W-1:0]  out_key_i,
  input logic [SLOT_IDX_W-1:0] out_slot_i,
  input logic                  out_last_i
);

  logic       in_acc;
  logic       last_acc;
  logic [1:0] open_q, open_d;

  assign in_acc   = in_valid_i && in_ready_i;
  assign last_acc = out_valid_i && out_ready_i && out_last_i;

  // items taken whose final beat has not left yet
  always_comb begin
    open_d = open_q;
    if (in_acc && !last_acc) begin
      open_d = open_q + 2'd1;
    end else if (!in_acc && last_acc) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_fired_i) && $stable(out_key_i) && $stable(out_slot_i) &&
      $stable(out_last_i))
    else $error("result beat changed while stalled");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_fired_i |-> out_status_i == ST_OK)
    else $error("fired beat with a non-ok status");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_last_i && !out_fired_i)
    else $error("error or ignore beat not a single final beat");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("result beat with no item open");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> open_q <= 2'd1)
    else $error("item taken while an earlier one is still in work");

endmodule

bind calendar_alarm_table_matcher_top catm_checker u_catm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_fired_i  (out_o.fired),
  .out_key_i    (out_o.fired_key),
  .out_slot_i   (out_o.slot_index),
  .out_last_i   (out_o.last)
);
